@@ src/fic_pkg.sv @@
// Shared types, constants and the CRC column table for the image checker.
package fic_pkg;

  localparam logic [31:0] CRC_POLY        = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
  localparam logic [15:0] MAX_WORDS_RESET = 16'd49152;

  typedef enum logic [1:0] {
    ST_MATCH     = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_t;

  typedef logic [31:0][31:0] crc_cols_t;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic [31:0] crc;
    logic [15:0] words;
  } result_t;

  // Column i is the 32-shift CRC remainder of a lone set bit i.
  function automatic crc_cols_t build_crc_cols();
    crc_cols_t   cols;
    logic [31:0] c;
    for (int i = 0; i < 32; i++) begin
      c = 32'h1 << i;
      for (int b = 0; b < 32; b++) begin
        c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam crc_cols_t CRC_COLS = build_crc_cols();

endpackage

@@ src/fic_cfg_regs.sv @@
// APB-style register file holding the image size limit.
module fic_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [15:0] max_words
);
  import fic_pkg::*;

  logic [15:0] max_words_r;
  logic [15:0] max_words_nxt;
  logic        wr_en;
  logic [1:0]  byte_off;

  assign byte_off = cfg_paddr;
  assign wr_en    = cfg_psel && cfg_penable && cfg_pwrite && (byte_off == byte_off);

  always_comb begin
    max_words_nxt = max_words_r;
    if (wr_en) begin
      max_words_nxt = cfg_pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_words_r <= MAX_WORDS_RESET;
    end else begin
      max_words_r <= max_words_nxt;
    end
  end

  assign cfg_prdata = {16'd0, max_words_r};
  assign cfg_pready = 1'b1;
  assign max_words  = max_words_r;

endmodule

@@ src/fic_crc_unit.sv @@
// One-word CRC-32 update as a flat XOR network.
module fic_crc_unit (
  input  logic [31:0] crc_in,
  input  logic [31:0] word,
  output logic [31:0] crc_out
);
  import fic_pkg::*;

  logic [31:0] mix;

  assign mix = crc_in ^ word;

  always_comb begin
    crc_out = '0;
    for (int i = 0; i < 32; i++) begin
      crc_out = crc_out ^ (mix[i] ? CRC_COLS[i] : 32'd0);
    end
  end

endmodule

@@ src/fic_core.sv @@
// Image tracking state and per-word decision logic.
module fic_core #(
  parameter int LENGTH_SLOT = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [31:0]      data_word,
  input  logic             start_image,
  input  logic [15:0]      max_words,
  output fic_pkg::result_t res
);
  import fic_pkg::*;

  localparam logic [15:0] SLOT_IDX = 16'(LENGTH_SLOT);
  localparam logic [29:0] SLOT_W   = 30'(LENGTH_SLOT);

  logic [31:0] crc_r, crc_nxt;
  logic [15:0] idx_r, idx_nxt;
  logic [15:0] len_r, len_nxt;
  logic        checking_r, checking_nxt;

  logic [31:0] crc_base, crc_new;
  logic [15:0] idx_base, len_base;
  logic        active;
  logic        is_crc_word;
  logic [29:0] words;
  logic [15:0] shown;
  logic        too_large;
  logic        too_small;

  fic_crc_unit u_crc (
    .crc_in  (crc_base),
    .word    (data_word),
    .crc_out (crc_new)
  );

  assign crc_base    = start_image ? CRC_INIT : crc_r;
  assign idx_base    = start_image ? 16'd0 : idx_r;
  assign len_base    = start_image ? 16'd0 : len_r;
  assign active      = start_image || checking_r;
  assign is_crc_word = (idx_base > SLOT_IDX) && (idx_base == len_base);
  assign words       = data_word[31:2];
  assign shown       = (words[29:16] != '0) ? 16'hFFFF : words[15:0];
  assign too_large   = (words[29:16] != '0) || (words[15:0] > max_words);
  assign too_small   = (words <= SLOT_W);

  always_comb begin
    res          = '0;
    res.status   = ST_MATCH;
    crc_nxt      = crc_base;
    idx_nxt      = idx_base;
    len_nxt      = len_base;
    checking_nxt = active;
    if (active) begin
      if (is_crc_word) begin
        res.valid    = 1'b1;
        res.status   = (data_word == crc_base) ? ST_MATCH : ST_MISMATCH;
        res.crc      = crc_base;
        res.words    = len_base;
        checking_nxt = 1'b0;
      end else begin
        crc_nxt = crc_new;
        idx_nxt = idx_base + 16'd1;
        if (idx_base == SLOT_IDX) begin
          if (too_large || too_small) begin
            res.valid    = 1'b1;
            res.status   = too_large ? ST_TOO_LARGE : ST_TOO_SMALL;
            res.crc      = crc_new;
            res.words    = shown;
            checking_nxt = 1'b0;
            idx_nxt      = idx_base;
          end else begin
            len_nxt = words[15:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= CRC_INIT;
      idx_r      <= '0;
      len_r      <= '0;
      checking_r <= 1'b0;
    end else if (step) begin
      crc_r      <= crc_nxt;
      idx_r      <= idx_nxt;
      len_r      <= len_nxt;
      checking_r <= checking_nxt;
    end
  end

  a_result_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid |=> !checking_r)
    else $error("image still open after its result");

  a_length_known: assert property (@(posedge clk) disable iff (!rst_n)
    checking_r && (idx_r > SLOT_IDX) |-> len_r > SLOT_IDX)
    else $error("past length slot without a valid length");

  a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    checking_r && (idx_r > SLOT_IDX) |-> idx_r <= len_r)
    else $error("word index ran past the CRC word");

endmodule

@@ src/firmware_image_crc_check.sv @@
// Firmware image CRC checker: takes one 32-bit image word per cycle unless
// in_stall is high, runs a CRC-32 (polynomial 0x04C11DB7, init all ones, MSB
// first, no reflection, no final XOR) over the image, reads the size in bytes
// from the length slot and compares the word after the image with the CRC.
// One beat is accepted every cycle unless in_stall is high; a result passes
// the input register and the single XOR network plus compare into the output
// register. While a held result is stalled and the next word also yields a
// result, in_stall rises in the same cycle. Status codes: 0 match, 1 mismatch,
// 2 image too large, 3 length too small. The limit register answers at every
// byte address and resets to 49152 words.
module firmware_image_crc_check #(
  parameter int LENGTH_SLOT = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic        in_start_image,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_computed_crc,
  output logic [15:0] out_image_words,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import fic_pkg::*;

  logic        in_vld_r, in_vld_nxt;
  logic [31:0] in_data_r;
  logic        in_start_r;
  logic        out_vld_r, out_vld_nxt;
  status_t     out_status_r;
  logic [31:0] out_crc_r;
  logic [15:0] out_words_r;

  logic        in_take;
  logic        adv;
  logic [15:0] max_words;
  result_t     res;

  fic_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_words   (max_words)
  );

  fic_core #(
    .LENGTH_SLOT (LENGTH_SLOT)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .data_word   (in_data_r),
    .start_image (in_start_r),
    .max_words   (max_words),
    .res         (res)
  );

  // advance the held beat unless its result would overwrite a stalled one
  assign adv      = in_vld_r && (!res.valid || !out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (!in_stall) begin
      in_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r;
    if (adv && res.valid) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r  <= in_data_word;
      in_start_r <= in_start_image;
    end
    if (adv && res.valid) begin
      out_status_r <= res.status;
      out_crc_r    <= res.crc;
      out_words_r  <= res.words;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_status       = out_status_r;
  assign out_computed_crc = out_crc_r;
  assign out_image_words  = out_words_r;

  a_small_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_status_r == ST_TOO_SMALL) |-> out_words_r <= 16'(LENGTH_SLOT))
    else $error("length-too-small result with a large size");

  a_compare_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && ((out_status_r == ST_MATCH) || (out_status_r == ST_MISMATCH))
      |-> out_words_r > 16'(LENGTH_SLOT))
    else $error("CRC compare with a size inside the header");

  a_large_words: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.valid && (res.status == ST_TOO_LARGE) |-> res.words >= max_words)
    else $error("too-large result within the limit");

endmodule
